FILE: rtl/rpvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvg_pkg
// Shared constants, tables and types of the polygon vertex generator.
// ----------------------------------------------------------------------------
package rpvg_pkg;

  localparam int ANGLE_BITS   = 16;                      // binary turn width
  localparam int MAX_SIDES    = 64;                      // side count clamp
  localparam int N_W          = $clog2(MAX_SIDES + 1);   // clamped side count
  localparam int COORD_W      = 16;
  localparam int RADIUS_W     = 15;
  localparam int SIDES_W      = 7;
  localparam int DEG_W        = 9;
  localparam int DEG_FULL     = 360;
  localparam int TURN_W       = 32;                      // CORDIC angle word
  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;
  localparam int XW           = 34;                      // CORDIC datapath
  localparam int GAIN_W       = 30;
  localparam int GAIN_SHIFT   = 30 - FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  // serial divider widths: one full turn over the side count
  localparam int DIV_NUM_W = ANGLE_BITS + 1;
  localparam int DIV_DEN_W = N_W;

  // base angle floor((deg * 2^16 + 180) / 360) = floor((deg * 2^13 + 22) / 45),
  // done as a reciprocal multiply by ceil(2^28 / 45); exact for deg below 360
  localparam int DEG_LSH      = ANGLE_BITS - 3;
  localparam int DEG_Y_W      = DEG_W + DEG_LSH;
  localparam int DEG_BIAS     = 22;
  localparam int DEG_RECIP_W  = 23;
  localparam int DEG_RECIP_SH = 28;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 23'd5965233;

  // arctangent of 2^-i in 32-bit turns
  localparam logic [TURN_W-1:0] ATAN_TURN32 [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0]       radius;
    logic [SIDES_W-1:0]        sides;
    logic [DEG_W-1:0]          rot_deg;
    logic                      solid;
  } rpvg_req_t;

  typedef struct packed {
    logic                      valid;
    logic [ANGLE_BITS-1:0]     angle;
    logic [RADIUS_W-1:0]       radius;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      solid;
    logic                      last;
  } rpvg_vtx_t;

endpackage

FILE: rtl/rpvg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpvg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rpvg_pkg::DIV_NUM_W-1:0]  num,
  input  logic [rpvg_pkg::DIV_DEN_W-1:0]  den,
  output logic                            busy,
  output logic                            done,
  output logic [rpvg_pkg::DIV_NUM_W-1:0]  quo,
  output logic [rpvg_pkg::DIV_DEN_W-1:0]  rem
);

  localparam int NW    = rpvg_pkg::DIV_NUM_W;
  localparam int DW    = rpvg_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dreg;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW-1:0]    rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    ge       = (trial >= {1'b0, dreg});
    rem_next = ge ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

FILE: rtl/rpvg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvg_seq
// Request capture, angle setup and per-vertex angle stepping.
// ----------------------------------------------------------------------------
module rpvg_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  rpvg_pkg::rpvg_req_t  req,
  input  logic                 adv,
  output rpvg_pkg::rpvg_vtx_t  vtx
);

  localparam int AB = rpvg_pkg::ANGLE_BITS;
  localparam int NW = rpvg_pkg::N_W;
  localparam int DN = rpvg_pkg::DIV_NUM_W;
  localparam int DD = rpvg_pkg::DIV_DEN_W;
  localparam int DG = rpvg_pkg::DEG_W;
  localparam int YW = rpvg_pkg::DEG_Y_W;
  localparam int PW = rpvg_pkg::DEG_Y_W + rpvg_pkg::DEG_RECIP_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_RUN} state_t;

  state_t  state;
  logic    accept;
  logic    start;
  logic [NW-1:0] n_clamp;
  logic [DG-1:0] deg_mod;
  logic [DN-1:0] num_turn;

  logic            busy_n, done_n;
  logic [DN-1:0]   quo_n;
  logic [DD-1:0]   rem_n;

  // per-request registers
  logic [NW-1:0]   n;
  logic [DG-1:0]   deg;
  logic [NW-1:0]   idx;
  logic [AB-1:0]   base;
  logic [AB-1:0]   qstep;
  logic [NW-1:0]   rstep;
  logic [AB-1:0]   step;
  logic [NW-1:0]   rem;
  logic signed [rpvg_pkg::COORD_W-1:0] cx, cy;
  logic [rpvg_pkg::RADIUS_W-1:0]       radius;
  logic            solid;

  logic            issue;
  logic            is_last;
  logic [NW:0]     rsum;
  logic            carry;
  logic [NW-1:0]   rem_next;
  logic [AB-1:0]   step_next;
  logic [YW-1:0]   deg_y;
  logic [PW-1:0]   base_prod;

  always_comb begin
    accept  = req_valid && req_ready;
    n_clamp = (int'(req.sides) >= rpvg_pkg::MAX_SIDES) ?
              NW'(rpvg_pkg::MAX_SIDES) : NW'(req.sides);
    deg_mod = (int'(req.rot_deg) >= rpvg_pkg::DEG_FULL) ?
              DG'(req.rot_deg - DG'(rpvg_pkg::DEG_FULL)) : req.rot_deg;
    num_turn = DN'(1) << AB;
    start    = accept && (n_clamp != '0);
  end

  // base angle by reciprocal multiply, settles while the divider runs
  always_comb begin
    deg_y     = YW'({deg, rpvg_pkg::DEG_LSH'(0)}) + YW'(rpvg_pkg::DEG_BIAS);
    base_prod = PW'(deg_y) * PW'(rpvg_pkg::DEG_RECIP);
  end

  rpvg_div u_div_turn (
    .clk(clk), .rst(rst), .start(start), .num(num_turn), .den(DD'(n_clamp)),
    .busy(busy_n), .done(done_n), .quo(quo_n), .rem(rem_n)
  );

  // step_i = floor((i * turn + n/2) / n), advanced by quotient and remainder
  always_comb begin
    req_ready = (state == S_IDLE);
    issue     = (state == S_RUN) && adv;
    is_last   = (idx == NW'(n - NW'(1)));
    rsum      = {1'b0, rem} + {1'b0, rstep};
    carry     = (rsum >= {1'b0, n});
    rem_next  = carry ? NW'(rsum - {1'b0, n}) : rsum[NW-1:0];
    step_next = step + qstep + AB'(carry);

    vtx.valid  = issue;
    vtx.angle  = base + step;
    vtx.radius = radius;
    vtx.cx     = cx;
    vtx.cy     = cy;
    vtx.solid  = solid;
    vtx.last   = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_DIV;
            n      <= n_clamp;
            deg    <= deg_mod;
            cx     <= req.cx;
            cy     <= req.cy;
            radius <= req.radius;
            solid  <= req.solid;
          end
        end
        S_DIV: begin
          if (done_n) begin
            state <= S_RUN;
            base  <= base_prod[rpvg_pkg::DEG_RECIP_SH +: AB];
            qstep <= quo_n[AB-1:0];
            rstep <= rem_n[NW-1:0];
            step  <= '0;
            rem   <= n >> 1;
            idx   <= '0;
          end
        end
        S_RUN: begin
          if (issue) begin
            step <= step_next;
            rem  <= rem_next;
            idx  <= idx + NW'(1);
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_done_in_setup: assert property (@(posedge clk) disable iff (rst)
    done_n |-> (state == S_DIV))
    else $error("divider finished outside angle setup");

  a_div_idle_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !busy_n)
    else $error("divider still running while vertices issue");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (rem < n))
    else $error("step remainder not below side count");

endmodule

FILE: rtl/rpvg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvg_cordic
// Pipelined rotator: gain scale, 24 CORDIC stages, round, offset, saturate.
// ----------------------------------------------------------------------------
module rpvg_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  rpvg_pkg::rpvg_vtx_t                 vtx,
  output logic                                adv,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpvg_pkg::COORD_W-1:0] out_x,
  output logic signed [rpvg_pkg::COORD_W-1:0] out_y,
  output logic                                out_fill,
  output logic                                out_last
);

  localparam int XW = rpvg_pkg::XW;
  localparam int NS = rpvg_pkg::CORDIC_STEPS;
  localparam int TW = rpvg_pkg::TURN_W;
  localparam int CW = rpvg_pkg::COORD_W;
  localparam int RW = rpvg_pkg::RADIUS_W;
  localparam int PW = RW + rpvg_pkg::GAIN_W;
  localparam int FB = rpvg_pkg::FRAC_BITS;
  localparam int OW = XW - FB;           // rounded offset width
  localparam int SW = OW + 1;            // centre + offset

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic                 solid;
    logic                 last;
    logic                 flip;
  } side_t;

  // stage 1: quadrant fold
  logic                 v1;
  side_t                sb1;
  logic [RW-1:0]        r1;
  logic signed [XW-1:0] z1;
  logic [TW-1:0]        a32;
  logic                 flip;

  // CORDIC stages, index 0 holds the scaled start vector
  logic [NS:0]          vld;
  side_t                sb [0:NS];
  logic signed [XW-1:0] xs [0:NS];
  logic signed [XW-1:0] ys [0:NS];
  logic signed [XW-1:0] zs [0:NS];
  logic [PW-1:0]        prod;

  // rounding stage
  logic                 vr;
  side_t                sbr;
  logic signed [XW-1:0] ux, uy;

  logic signed [OW-1:0] offx, offy;
  logic signed [SW-1:0] sumx, sumy;

  always_comb begin
    adv  = !out_valid || out_ready;
    a32  = TW'(vtx.angle) << (TW - rpvg_pkg::ANGLE_BITS);
    flip = a32[TW-1] ^ a32[TW-2];
    prod = PW'(r1) * PW'(rpvg_pkg::GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1       <= vtx.valid;
      sb1.cx   <= vtx.cx;
      sb1.cy   <= vtx.cy;
      sb1.solid <= vtx.solid;
      sb1.last <= vtx.last;
      sb1.flip <= flip;
      r1       <= vtx.radius;
      z1       <= XW'(signed'(a32 ^ {flip, (TW-1)'(0)}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= v1;
      sb[0]  <= sb1;
      xs[0]  <= signed'(XW'(prod >> rpvg_pkg::GAIN_SHIFT));
      ys[0]  <= '0;
      zs[0]  <= z1;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [XW-1:0] dx, dy, da;
    logic                 pos;
    always_comb begin
      dx  = ys[k] >>> k;
      dy  = xs[k] >>> k;
      da  = signed'(XW'(rpvg_pkg::ATAN_TURN32[k]));
      pos = !zs[k][XW-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
        sb[k+1]  <= sb[k];
        xs[k+1]  <= pos ? xs[k] - dx : xs[k] + dx;
        ys[k+1]  <= pos ? ys[k] + dy : ys[k] - dy;
        zs[k+1]  <= pos ? zs[k] - da : zs[k] + da;
      end
    end
  end

  // negate folded quadrants and add the half-pixel in one add
  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr  <= vld[NS];
      sbr <= sb[NS];
      ux  <= sb[NS].flip ? (~xs[NS]) + XW'(2 ** (FB - 1) + 1)
                         : xs[NS] + XW'(2 ** (FB - 1));
      uy  <= sb[NS].flip ? (~ys[NS]) + XW'(2 ** (FB - 1) + 1)
                         : ys[NS] + XW'(2 ** (FB - 1));
    end
  end

  always_comb begin
    offx = ux[XW-1:FB];
    offy = uy[XW-1:FB];
    sumx = SW'(sbr.cx) + SW'(offx);
    sumy = SW'(sbr.cy) + SW'(offy);
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(2 ** (CW - 1) - 1);
    lo = -SW'(2 ** (CW - 1));
    if (v > hi) begin
      sat = hi[CW-1:0];
    end else if (v < lo) begin
      sat = lo[CW-1:0];
    end else begin
      sat = v[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vr;
      out_x     <= sat(sumx);
      out_y     <= sat(sumy);
      out_fill  <= sbr.solid;
      out_last  <= sbr.last;
    end
  end

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(vld) && $stable(vr) && $stable(v1)))
    else $error("pipeline moved during a stall");

endmodule

FILE: rtl/regular_polygon_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator
// Emits the vertices of a regular polygon from a centre/radius/sides request.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser      tlast
//  s_axis    in   cx[15:0] cy[31:16] radius[46:32]        solid      -
//                 sides[53:47] rotation_deg[62:54]
//  m_axis    out  vertex_x[15:0] vertex_y[31:16]          fill_mode  last
//
//  A request first goes through angle setup (a serial division of the turn by
//  the side count, one quotient bit a cycle, then a hand-over to the stepper)
//  and then issues one vertex per cycle while m_axis does not stall, so the
//  next request is taken once the last vertex of one has issued; a request
//  with zero sides is taken and dropped. The rotator is a 28-stage pipeline
//  (fold, gain multiply, 24 CORDIC stages, round, offset/saturate).
//  Reset (rst, synchronous) clears the sequencer state and all valid bits.
//  A stall on m_axis freezes every pipeline stage; nothing is lost or sent
//  twice, and a new request is taken as soon as the sequencer is free.
//
module regular_polygon_vertex_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // center_x, center_y, radius, sides, rotation_deg
  input  logic        s_axis_tuser,   // solid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // vertex_x, vertex_y
  output logic        m_axis_tuser,   // fill_mode
  output logic        m_axis_tlast    // last vertex of the polygon
);

  rpvg_pkg::rpvg_req_t req;
  rpvg_pkg::rpvg_vtx_t vtx;
  logic                adv;
  logic signed [rpvg_pkg::COORD_W-1:0] vx, vy;

  // unpack the request transaction
  always_comb begin
    req.cx      = s_axis_tdata[15:0];
    req.cy      = s_axis_tdata[31:16];
    req.radius  = s_axis_tdata[46:32];
    req.sides   = s_axis_tdata[53:47];
    req.rot_deg = s_axis_tdata[62:54];
    req.solid   = s_axis_tuser;
  end

  // request sequencer: setup division, then one angle per cycle while the rotator advances
  rpvg_seq u_seq (
    .clk(clk), .rst(rst),
    .req_valid(s_axis_tvalid), .req_ready(s_axis_tready), .req(req),
    .adv(adv), .vtx(vtx)
  );

  // rotator pipeline; its last stage is the output register
  rpvg_cordic u_cordic (
    .clk(clk), .rst(rst), .vtx(vtx), .adv(adv),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_x(vx), .out_y(vy), .out_fill(m_axis_tuser), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {vy, vx};

endmodule
